// ===== rtl/core/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, fixed-point constants, the arctangent table and the angle
// rounding helper of the quaternion to Euler angle unit.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int Q_W     = 16;   // quaternion component, Q2.14
  localparam int PROD_W  = 32;   // one component product, Q.28
  localparam int SUM_W   = 33;   // atan2 operands, Q.28
  localparam int ARGR_W  = 34;   // unclamped arcsine argument
  localparam int ARG_W   = 30;   // clamped arcsine argument, holds +-2^28
  localparam int V_W     = 57;   // radicand 2^56 - arg^2
  localparam int R_W     = V_W + 1;
  localparam int SQ_STEPS = (V_W + 1) / 2;
  localparam int ROOT_W  = SQ_STEPS;
  localparam int CORD_DW = 36;   // CORDIC x/y datapath
  localparam int CORD_ZW = 34;   // CORDIC angle, Q.30
  localparam int ATAN_W  = 30;
  localparam int ATAN_N  = 31;
  localparam int RND_SH  = 17;   // Q.30 -> Q3.13
  localparam int ANGQ_W  = CORD_ZW - RND_SH;
  localparam int ANG_W   = 16;
  localparam int PITCH_W = 15;

  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic signed [ARGR_W-1:0] ONE_Q28   = ARGR_W'(64'sd268435456);
  localparam logic signed [SUM_W-1:0]  HALF_Q28  = SUM_W'(64'sd134217728);
  localparam logic [V_W-1:0]           ONE_SQ    = V_W'(1) << 56;
  localparam logic signed [CORD_ZW-1:0] HALFPI_Q30 = CORD_ZW'(64'sd1686629713);
  localparam logic signed [CORD_ZW-1:0] RND_HALF   = CORD_ZW'(64'sd65536);
  localparam logic signed [ANGQ_W-1:0]  PI_Q13     = ANGQ_W'(25736);
  localparam logic signed [ANGQ_W-1:0]  HALFPI_Q13 = ANGQ_W'(12868);

  // atan(2^-i) in Q.30, truncated
  localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_N] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
    30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
    30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
    30'd31,        30'd15,        30'd8,         30'd4,         30'd2,
    30'd1
  };

  typedef struct packed {
    logic signed [SUM_W-1:0] rn;
    logic signed [SUM_W-1:0] rd;
    logic signed [SUM_W-1:0] yn;
    logic signed [SUM_W-1:0] yd;
    logic signed [ARG_W-1:0] arg;
    logic                    clamped;
  } q2e_side_t;

  // Round Q.30 to Q3.13 (add half, floor shift) and saturate to +-lim
  function automatic logic signed [ANGQ_W-1:0] to_q13(
    input logic signed [CORD_ZW-1:0] a,
    input logic signed [ANGQ_W-1:0]  lim
  );
    logic signed [CORD_ZW-1:0] s;
    logic signed [ANGQ_W-1:0]  r;
    s = a + RND_HALF;
    r = s[CORD_ZW-1:RND_SH];
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

endpackage

// ===== rtl/core/q2e_front.sv =====
// ----------------------------------------------------------------------------
// q2e_front
// Products, atan2 operands, arcsine clamp and the square-root radicand.
// Four register stages.
// ----------------------------------------------------------------------------
module q2e_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [q2e_pkg::Q_W-1:0]  quat_w,
  input  logic signed [q2e_pkg::Q_W-1:0]  quat_x,
  input  logic signed [q2e_pkg::Q_W-1:0]  quat_y,
  input  logic signed [q2e_pkg::Q_W-1:0]  quat_z,
  output logic                            rad_valid,
  output logic [q2e_pkg::V_W-1:0]         rad,
  output q2e_pkg::q2e_side_t              side
);
  import q2e_pkg::*;

  logic signed [PROD_W-1:0] we, xe, ye, ze;
  logic signed [PROD_W-1:0] p_wx, p_yz, p_xx, p_yy, p_zz, p_xy, p_wz, p_wy, p_xz;
  logic                     s1_valid, s2_valid, s3_valid;
  logic signed [ARGR_W-1:0] diff, arg2;
  q2e_side_t                side_next, s2_side, s3_side;
  logic signed [2*ARG_W-1:0] sq_full;
  logic [V_W-1:0]           sq;

  assign we = PROD_W'(quat_w);
  assign xe = PROD_W'(quat_x);
  assign ye = PROD_W'(quat_y);
  assign ze = PROD_W'(quat_z);

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= in_valid;
    if (en) begin
      p_wx <= we * xe;
      p_yz <= ye * ze;
      p_xx <= xe * xe;
      p_yy <= ye * ye;
      p_zz <= ze * ze;
      p_xy <= xe * ye;
      p_wz <= we * ze;
      p_wy <= we * ye;
      p_xz <= xe * ze;
    end
  end

  // stage 2: sums and clamp
  always_comb begin
    diff = ARGR_W'(p_wy) - ARGR_W'(p_xz);
    arg2 = diff <<< 1;
    side_next.rn = SUM_W'(p_wx) + SUM_W'(p_yz);
    side_next.rd = HALF_Q28 - SUM_W'(p_xx) - SUM_W'(p_yy);
    side_next.yn = SUM_W'(p_xy) + SUM_W'(p_wz);
    side_next.yd = HALF_Q28 - SUM_W'(p_yy) - SUM_W'(p_zz);
    side_next.clamped = 1'b0;
    side_next.arg = arg2[ARG_W-1:0];
    if (arg2 > ONE_Q28) begin
      side_next.arg = ONE_Q28[ARG_W-1:0];
      side_next.clamped = 1'b1;
    end else if (arg2 < -ONE_Q28) begin
      side_next.arg = ARG_W'(-ONE_Q28);
      side_next.clamped = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
    if (en) s2_side <= side_next;
  end

  // stage 3: square of the arcsine argument
  assign sq_full = s2_side.arg * s2_side.arg;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= s2_valid;
    if (en) begin
      sq      <= sq_full[V_W-1:0];
      s3_side <= s2_side;
    end
  end

  // stage 4: radicand 1 - arg^2
  always_ff @(posedge clk) begin
    if (rst) rad_valid <= 1'b0;
    else if (en) rad_valid <= s3_valid;
    if (en) begin
      rad  <= ONE_SQ - sq;
      side <= s3_side;
    end
  end

endmodule

// ===== rtl/core/q2e_isqrt.sv =====
// ----------------------------------------------------------------------------
// q2e_isqrt
// Floor integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module q2e_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [q2e_pkg::V_W-1:0]       rad,
  input  q2e_pkg::q2e_side_t            side_in,
  output logic                          out_valid,
  output logic [q2e_pkg::ROOT_W-1:0]    root,
  output q2e_pkg::q2e_side_t            side_out
);
  import q2e_pkg::*;

  logic [V_W-1:0] v_q     [SQ_STEPS+1];
  logic [R_W-1:0] r_q     [SQ_STEPS+1];
  q2e_side_t      side_q  [SQ_STEPS+1];
  logic           valid_q [SQ_STEPS+1];

  assign v_q[0]     = rad;
  assign r_q[0]     = '0;
  assign side_q[0]  = side_in;
  assign valid_q[0] = in_valid;

  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
    localparam logic [R_W-1:0] BIT = R_W'(1) << (2 * (SQ_STEPS - 1 - s));
    logic [R_W-1:0] rb;
    logic           take;

    assign rb   = r_q[s] + BIT;
    assign take = R_W'(v_q[s]) >= rb;

    always_ff @(posedge clk) begin
      if (rst) valid_q[s+1] <= 1'b0;
      else if (en) valid_q[s+1] <= valid_q[s];
      if (en) begin
        v_q[s+1]    <= take ? V_W'(R_W'(v_q[s]) - rb) : v_q[s];
        r_q[s+1]    <= take ? (r_q[s] >> 1) + BIT : r_q[s] >> 1;
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign out_valid = valid_q[SQ_STEPS];
  assign root      = r_q[SQ_STEPS][ROOT_W-1:0];
  assign side_out  = side_q[SQ_STEPS];

endmodule

// ===== rtl/core/q2e_cordic.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC, atan2(num, den) in Q.30. A quadrant stage
// folds a negative den into the right half plane, then one stage per
// micro-rotation.
// ----------------------------------------------------------------------------
module q2e_cordic #(
  parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [q2e_pkg::SUM_W-1:0]    num,
  input  logic signed [q2e_pkg::SUM_W-1:0]    den,
  output logic                                out_valid,
  output logic signed [q2e_pkg::CORD_ZW-1:0]  angle,
  output logic                                out_zero
);
  import q2e_pkg::*;

  logic signed [CORD_DW-1:0] x_q [STAGES+1];
  logic signed [CORD_DW-1:0] y_q [STAGES+1];
  logic signed [CORD_ZW-1:0] z_q [STAGES+1];
  logic                      zero_q  [STAGES+1];
  logic                      valid_q [STAGES+1];
  logic signed [CORD_DW-1:0] xe, ye;

  assign xe = CORD_DW'(den);
  assign ye = CORD_DW'(num);

  // quadrant stage
  always_ff @(posedge clk) begin
    if (rst) valid_q[0] <= 1'b0;
    else if (en) valid_q[0] <= in_valid;
    if (en) begin
      zero_q[0] <= (den == '0) && (num == '0);
      if (den < 0 && num >= 0) begin
        x_q[0] <= ye;
        y_q[0] <= -xe;
        z_q[0] <= HALFPI_Q30;
      end else if (den < 0) begin
        x_q[0] <= -ye;
        y_q[0] <= xe;
        z_q[0] <= -HALFPI_Q30;
      end else begin
        x_q[0] <= xe;
        y_q[0] <= ye;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [CORD_ZW-1:0] ATN = CORD_ZW'(ATAN_TAB[i]);
    logic signed [CORD_DW-1:0] dx, dy;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) valid_q[i+1] <= 1'b0;
      else if (en) valid_q[i+1] <= valid_q[i];
      if (en) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ATN;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ATN;
        end
      end
    end
  end

  assign out_valid = valid_q[STAGES];
  assign angle     = z_q[STAGES];
  assign out_zero  = zero_q[STAGES];

endmodule

// ===== rtl/core/quaternion_to_euler_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit
// Unit quaternion (Q2.14) to ZYX roll, pitch, yaw in radians (Q3.13).
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   input   | in_valid/in_stall  | quat_w, quat_x, quat_y, quat_z
//   output  | out_valid/out_stall| roll_angle, pitch_angle, yaw_angle,
//           |                    | pitch_clamped
//
// One item per cycle unless the pipe is frozen by out_stall. The pipe is
// 4 front stages, 29 square-root stages, 1 + CORDIC_STAGES CORDIC stages,
// 1 output register. The square root sets the depth.
// rst clears every valid bit; payload registers are not reset.
// The whole pipe advances together; it freezes only while a result sits in
// the output register and out_stall is high, so no item is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_to_euler_unit #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [q2e_pkg::Q_W-1:0]      quat_w,
  input  logic signed [q2e_pkg::Q_W-1:0]      quat_x,
  input  logic signed [q2e_pkg::Q_W-1:0]      quat_y,
  input  logic signed [q2e_pkg::Q_W-1:0]      quat_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [q2e_pkg::ANG_W-1:0]    roll_angle,
  output logic signed [q2e_pkg::PITCH_W-1:0]  pitch_angle,
  output logic signed [q2e_pkg::ANG_W-1:0]    yaw_angle,
  output logic                                pitch_clamped
);
  import q2e_pkg::*;

  logic                      en;
  logic                      rad_valid, sq_valid;
  logic [V_W-1:0]            rad;
  q2e_side_t                 side_f, side_s;
  logic [ROOT_W-1:0]         root;
  logic signed [SUM_W-1:0]   pitch_num, pitch_den;
  logic                      v_roll, v_pitch, v_yaw;
  logic signed [CORD_ZW-1:0] a_roll, a_pitch, a_yaw;
  logic                      z_roll, z_pitch, z_yaw;
  logic                      clamp_q [CORDIC_STAGES+1];
  logic signed [ANGQ_W-1:0]  q_roll, q_pitch, q_yaw;

  // global advance: output register empty or being taken
  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  q2e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .rad_valid (rad_valid),
    .rad       (rad),
    .side      (side_f)
  );

  q2e_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rad_valid),
    .rad       (rad),
    .side_in   (side_f),
    .out_valid (sq_valid),
    .root      (root),
    .side_out  (side_s)
  );

  // pitch = atan2(t, sqrt(1 - t^2))
  assign pitch_num = SUM_W'(side_s.arg);
  assign pitch_den = $signed(SUM_W'(root));

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk (clk), .rst (rst), .en (en), .in_valid (sq_valid),
    .num (side_s.rn), .den (side_s.rd),
    .out_valid (v_roll), .angle (a_roll), .out_zero (z_roll)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk (clk), .rst (rst), .en (en), .in_valid (sq_valid),
    .num (pitch_num), .den (pitch_den),
    .out_valid (v_pitch), .angle (a_pitch), .out_zero (z_pitch)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk (clk), .rst (rst), .en (en), .in_valid (sq_valid),
    .num (side_s.yn), .den (side_s.yd),
    .out_valid (v_yaw), .angle (a_yaw), .out_zero (z_yaw)
  );

  // clamp flag rides alongside the CORDIC stages
  always_ff @(posedge clk) begin
    if (en) clamp_q[0] <= side_s.clamped;
  end
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_clamp
    always_ff @(posedge clk) begin
      if (en) clamp_q[i+1] <= clamp_q[i];
    end
  end

  assign q_roll  = z_roll  ? '0 : to_q13(a_roll, PI_Q13);
  assign q_pitch = z_pitch ? '0 : to_q13(a_pitch, HALFPI_Q13);
  assign q_yaw   = z_yaw   ? '0 : to_q13(a_yaw, PI_Q13);

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v_roll;
    if (en) begin
      roll_angle    <= q_roll[ANG_W-1:0];
      pitch_angle   <= q_pitch[PITCH_W-1:0];
      yaw_angle     <= q_yaw[ANG_W-1:0];
      pitch_clamped <= clamp_q[CORDIC_STAGES];
    end
  end

  // the three CORDIC pipes run in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    (v_roll == v_pitch) && (v_roll == v_yaw))
    else $error("CORDIC valid bits out of step");

  a_pitch_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_angle <= $signed(PITCH_W'(12868)))
               && (pitch_angle >= -$signed(PITCH_W'(12868))))
    else $error("pitch beyond +-pi/2");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(a_roll) && $stable(v_roll))
    else $error("pipe moved while stalled");

endmodule

// ===== verif/tb_quaternion_to_euler_unit.sv =====
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_unit
// Drives quaternions through the Euler angle unit under random idle and stall
// phases and compares every result item with a bit-exact local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quaternion_to_euler_unit;
  import q2e_pkg::*;

  localparam int STAGES    = CORDIC_STAGES_DEF;
  localparam int LATENCY   = STAGES + 35;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1450;
  localparam longint HALFPI30 = 64'sd1686629713;
  localparam longint UNIT28   = 64'sd268435456;

  // idle/stall phases
  typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} phase_t;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic pitch_clamped;

  quat_t  pending_quats[$];
  euler_t expected_angles[$];
  phase_t phase = PH_NONE;
  int     errors = 0;
  int     wdog = 0;
  int     hold_recv = 0;   // long receiver hold-off, counted down by monitor
  bit     drain_pause = 0; // sender waits until nothing is expected

  always #5 clk = ~clk;

  quaternion_to_euler_unit uut (
    .clk, .rst, .in_valid, .in_stall, .quat_w, .quat_x, .quat_y, .quat_z,
    .out_valid, .out_stall, .roll_angle, .pitch_angle, .yaw_angle, .pitch_clamped
  );

  // floor shift for negatives too
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // vectoring CORDIC, angle in Q.30
  function automatic longint vector_angle(longint yv, longint xv);
    longint x, y, a, t, dx, dy;
    x = xv;
    y = yv;
    a = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; a = HALFPI30;
      end else begin
        t = x; x = -y; y = t; a = -HALFPI30;
      end
    end
    for (int i = 0; i < STAGES && i < 31; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; a += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; a -= longint'(ATAN_TAB[i]);
      end
    end
    return a;
  endfunction

  function automatic longint round_angle(longint a30, longint lim);
    longint r;
    r = floor_shift(a30 + 65536, 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t predict_euler(quat_t q);
    longint w, x, y, z, rn, rd, yn, yd, arg, c;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    rn = w * x + y * z;
    rd = UNIT28 / 2 - x * x - y * y;
    yn = x * y + w * z;
    yd = UNIT28 / 2 - y * y - z * z;
    arg = 2 * (w * y - x * z);
    e.clamped = 1'b0;
    if (arg > UNIT28) begin arg = UNIT28; e.clamped = 1'b1; end
    if (arg < -UNIT28) begin arg = -UNIT28; e.clamped = 1'b1; end
    c = floor_sqrt(longint'(UNIT28 * UNIT28 - arg * arg));
    e.roll  = 16'(round_angle(vector_angle(rn, rd), 25736));
    e.pitch = 15'(round_angle(vector_angle(arg, c), 12868));
    e.yaw   = 16'(round_angle(vector_angle(yn, yd), 25736));
    return e;
  endfunction

  function automatic bit take_chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic signed [15:0] rand_comp();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // Random unit quaternion, normalized with real math then quantized.
  function automatic quat_t rand_unit_quat();
    real a[4], n;
    quat_t q;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      a[i] = $itor($signed($urandom_range(2000)) - 1000);
      n += a[i] * a[i];
    end
    if (n == 0.0) begin a[0] = 1.0; n = 1.0; end
    n = $sqrt(n);
    q.w = 16'($rtoi(a[0] / n * 16384.0));
    q.x = 16'($rtoi(a[1] / n * 16384.0));
    q.y = 16'($rtoi(a[2] / n * 16384.0));
    q.z = 16'($rtoi(a[3] / n * 16384.0));
    return q;
  endfunction

  // Driver: a valid item is held until accepted; one NBA per signal per edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_angles.push_back(predict_euler({quat_w, quat_x, quat_y, quat_z}));
        void'(pending_quats.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (pending_quats.size() > 0 &&
            !(drain_pause && expected_angles.size() != 0) &&
            !((phase == PH_SEND && take_chance(69)) ||
              (phase == PH_BOTH && take_chance(7)))) begin
          in_valid <= 1'b1;
          {quat_w, quat_x, quat_y, quat_z} <= pending_quats[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor, receiver stall and watchdog.
  always @(posedge clk) begin
    euler_t got, exp_e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {roll_angle, pitch_angle, yaw_angle, pitch_clamped};
        if (expected_angles.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          exp_e = expected_angles.pop_front();
          if (got.roll !== exp_e.roll) begin
            $error("roll_angle: expected %0d got %0d", exp_e.roll, got.roll); errors++;
          end
          if (got.pitch !== exp_e.pitch) begin
            $error("pitch_angle: expected %0d got %0d", exp_e.pitch, got.pitch); errors++;
          end
          if (got.yaw !== exp_e.yaw) begin
            $error("yaw_angle: expected %0d got %0d", exp_e.yaw, got.yaw); errors++;
          end
          if (got.clamped !== exp_e.clamped) begin
            $error("pitch_clamped: expected %0d got %0d", exp_e.clamped, got.clamped);
            errors++;
          end
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || hold_recv > 0) wdog <= 0;
      else wdog <= wdog + 1;
      if (hold_recv > 0) begin
        hold_recv <= hold_recv - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (phase == PH_RECV && take_chance(69)) ||
                     (phase == PH_BOTH && take_chance(7));
      end
      if (wdog >= WDOG_MAX) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic run_items(int n, phase_t ph);
    int r;
    phase = ph;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 80) pending_quats.push_back(rand_unit_quat());
      else pending_quats.push_back({rand_comp(), rand_comp(), rand_comp(), rand_comp()});
    end
    while (pending_quats.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: identity, axis turns, extremes, gimbal lock, zero vectors
    pending_quats.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back({-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    pending_quats.push_back({16'sd0, -16'sd16384, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd0, -16'sd16384, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, -16'sd16384});
    pending_quats.push_back({16'sd11585, 16'sd0, 16'sd11585, 16'sd0});   // pitch +pi/2
    pending_quats.push_back({16'sd11585, 16'sd0, -16'sd11585, 16'sd0});  // pitch -pi/2
    pending_quats.push_back({16'sd16384, 16'sd0, 16'sd16384, 16'sd0});   // clamp high
    pending_quats.push_back({16'sd16384, 16'sd0, -16'sd16384, 16'sd0});  // clamp low
    pending_quats.push_back({16'sd0, 16'sd16384, 16'sd0, 16'sd16384});   // clamp via xz
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0});           // all zero
    pending_quats.push_back({16'sd0, 16'sd11585, 16'sd0, 16'sd0});       // roll denominator near zero
    pending_quats.push_back({16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
    pending_quats.push_back({-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384});
    pending_quats.push_back({16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    pending_quats.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    pending_quats.push_back({16'hffff, 16'hffff, 16'hffff, 16'hffff});
    pending_quats.push_back({16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
    pending_quats.push_back({16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192});
    while (pending_quats.size() != 0) @(posedge clk);

    run_items(300, PH_NONE);
    run_items(300, PH_SEND);
    run_items(300, PH_RECV);
    run_items(250, PH_BOTH);

    // long receiver hold-off while the sender keeps offering: fills the pipe
    phase = PH_NONE;
    hold_recv = 4 * LATENCY;
    run_items(150, PH_NONE);

    // sender pauses until every result is back
    drain_pause = 1;
    run_items(150, PH_BOTH);
    drain_pause = 0;

    while (expected_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_angles.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
